// File: rtl/priority_tick_scheduler_unit_defines.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef PRIORITY_TICK_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_TICK_SCHEDULER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define PTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pts_pkg.sv
package pts_pkg;

  // Default table size and fixed field widths.
  localparam int NumTasksDef = 8;
  localparam int TaskIdxW    = 6;
  localparam int ValueW      = 8;
  localparam int CmdW        = 2;

  typedef enum logic [CmdW-1:0] {
    CmdSetPrio  = 2'd0,
    CmdSetBlock = 2'd1,
    CmdSched    = 2'd2,
    CmdTick     = 2'd3
  } pts_cmd_e;

  // One task entry as stored in the table.
  typedef struct packed {
    logic              blocked;
    logic [ValueW-1:0] prio;
    logic [ValueW-1:0] budget;
  } pts_entry_t;

  // Port strobes from the sequencer to the task table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } pts_mem_ctrl_t;

endpackage

// File: rtl/pts_task_mem.sv
module pts_task_mem #(
  parameter int NUM_TASKS = pts_pkg::NumTasksDef,
  parameter int IDX_W     = $clog2(NUM_TASKS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pts_pkg::pts_mem_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  pts_pkg::pts_entry_t   wr_data_i,
  output pts_pkg::pts_entry_t   rd_data_o
);
  import pts_pkg::*;

  pts_entry_t             mem_q [NUM_TASKS];
  pts_entry_t             rd_raw_q;
  logic                   rd_vld_q;
  logic [NUM_TASKS-1:0]   vld_q;

  // Track which entries were written since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Write and read the table, read data registered.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_raw_q <= mem_q[rd_addr_i];
    end
  end

  // An entry never written reads as zero.
  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

// File: rtl/priority_tick_scheduler_unit.sv
// Priority tick scheduler: task table in one synchronous RAM, walked by a sequencer.
// Set priority / set blocked read-modify-write one entry; an out-of-range task skips the table.
// Schedule walks the table once, tick updates the current budget first, and a reload walks it again.
// Throughput: one request at a time, bounded by the one-entry-per-cycle table walk; input stall
// drops as the result register loads, and a result held by out_stall_i holds the sequencer.
// Reset: rst_ni (async, low) clears current task, valid bits and control; all entries read zero.
`include "priority_tick_scheduler_unit_defines.svh"

module priority_tick_scheduler_unit #(
  parameter int NUM_TASKS = pts_pkg::NumTasksDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pts_pkg::CmdW-1:0]    cmd_i,
  input  logic [pts_pkg::TaskIdxW-1:0] task_index_i,
  input  logic [pts_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pts_pkg::TaskIdxW-1:0] current_task_o,
  output logic                        picked_o,
  output logic                        reloaded_o
);
  import pts_pkg::*;

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_TICK,
    S_SCAN,
    S_DECIDE,
    S_RELOAD,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  pts_cmd_e            cmd_q, cmd_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [ValueW-1:0]   val_q, val_d;
  logic [CNT_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic                ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]    ev_idx_q, ev_idx_d;
  logic [ValueW-1:0]   best_q, best_d;
  logic [IDX_W-1:0]    cand_q, cand_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic                res_pick_q, res_pick_d;
  logic                res_reld_q, res_reld_d;
  logic                out_vld_q, out_vld_d;
  logic [TaskIdxW-1:0] out_cur_q, out_cur_d;
  logic                out_pick_q, out_pick_d;
  logic                out_reld_q, out_reld_d;

  pts_mem_ctrl_t       mem_ctrl;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  pts_entry_t          wr_data;
  pts_entry_t          rd_data;
  logic                idx_in_range;
  logic                ev_last;

  pts_task_mem #(
    .NUM_TASKS (NUM_TASKS),
    .IDX_W     (IDX_W)
  ) u_task_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  assign idx_in_range = (7'(task_index_i) < 7'(NUM_TASKS));
  assign ev_last      = (ev_idx_q == IDX_W'(NUM_TASKS - 1));

  // Sequence commands through the task table.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    val_d      = val_q;
    rd_ptr_d   = rd_ptr_q;
    ev_vld_d   = 1'b0;
    ev_idx_d   = ev_idx_q;
    best_d     = best_q;
    cand_d     = cand_q;
    cur_d      = cur_q;
    res_pick_d = res_pick_q;
    res_reld_d = res_reld_q;
    out_cur_d  = out_cur_q;
    out_pick_d = out_pick_q;
    out_reld_d = out_reld_q;
    // drain the output register
    out_vld_d  = out_vld_q & out_stall_i;
    mem_ctrl   = '0;
    rd_addr    = '0;
    wr_addr    = '0;
    wr_data    = rd_data;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = pts_cmd_e'(cmd_i);
          idx_d      = task_index_i[IDX_W-1:0];
          val_d      = value_i;
          rd_ptr_d   = '0;
          best_d     = '0;
          cand_d     = '0;
          res_pick_d = 1'b0;
          res_reld_d = 1'b0;
          unique case (pts_cmd_e'(cmd_i))
            CmdSetPrio, CmdSetBlock: begin
              if (idx_in_range) begin
                mem_ctrl.rd_en = 1'b1;
                rd_addr        = task_index_i[IDX_W-1:0];
                state_d        = S_RMW;
              end else begin
                state_d = S_DONE;
              end
            end
            CmdSched: begin
              state_d = S_SCAN;
            end
            CmdTick: begin
              mem_ctrl.rd_en = 1'b1;
              rd_addr        = cur_q;
              state_d        = S_TICK;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_RMW: begin
        mem_ctrl.wr_en = 1'b1;
        wr_addr        = idx_q;
        if (cmd_q == CmdSetPrio) begin
          wr_data.prio   = val_q;
          wr_data.budget = val_q;
        end else begin
          wr_data.blocked = val_q[0];
        end
        state_d = S_DONE;
      end

      S_TICK: begin
        // take one tick from the current budget, never below zero
        mem_ctrl.wr_en = 1'b1;
        wr_addr        = cur_q;
        wr_data.budget = rd_data.budget - ValueW'(rd_data.budget != '0);
        state_d        = S_SCAN;
      end

      S_SCAN, S_RELOAD: begin
        // issue one read per cycle, evaluate each entry in the cycle after its read
        if (rd_ptr_q < CNT_W'(NUM_TASKS)) begin
          mem_ctrl.rd_en = 1'b1;
          rd_addr        = rd_ptr_q[IDX_W-1:0];
          rd_ptr_d       = CNT_W'(rd_ptr_q + 1'b1);
          ev_vld_d       = 1'b1;
          ev_idx_d       = rd_ptr_q[IDX_W-1:0];
        end
        if (ev_vld_q) begin
          if (state_q == S_SCAN) begin
            if (!rd_data.blocked && (rd_data.budget > best_q)) begin
              best_d = rd_data.budget;
              cand_d = ev_idx_q;
            end
            if (ev_last) begin
              state_d = S_DECIDE;
            end
          end else begin
            mem_ctrl.wr_en = 1'b1;
            wr_addr        = ev_idx_q;
            wr_data.budget = rd_data.prio;
            if (ev_last) begin
              state_d = S_DONE;
            end
          end
        end
      end

      S_DECIDE: begin
        if (best_q != '0) begin
          cur_d      = cand_q;
          res_pick_d = 1'b1;
          state_d    = S_DONE;
        end else begin
          res_reld_d = 1'b1;
          rd_ptr_d   = '0;
          state_d    = S_RELOAD;
        end
      end

      S_DONE: begin
        // hand the result over once the output slot is free
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d  = 1'b1;
          out_cur_d  = TaskIdxW'(cur_q);
          out_pick_d = res_pick_q;
          out_reld_d = res_reld_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ev_vld_q   <= 1'b0;
      cur_q      <= '0;
      out_vld_q  <= 1'b0;
      cmd_q      <= CmdSched;
      idx_q      <= '0;
      val_q      <= '0;
      rd_ptr_q   <= '0;
      ev_idx_q   <= '0;
      best_q     <= '0;
      cand_q     <= '0;
      res_pick_q <= 1'b0;
      res_reld_q <= 1'b0;
      out_cur_q  <= '0;
      out_pick_q <= 1'b0;
      out_reld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ev_vld_q   <= ev_vld_d;
      cur_q      <= cur_d;
      out_vld_q  <= out_vld_d;
      cmd_q      <= cmd_d;
      idx_q      <= idx_d;
      val_q      <= val_d;
      rd_ptr_q   <= rd_ptr_d;
      ev_idx_q   <= ev_idx_d;
      best_q     <= best_d;
      cand_q     <= cand_d;
      res_pick_q <= res_pick_d;
      res_reld_q <= res_reld_d;
      out_cur_q  <= out_cur_d;
      out_pick_q <= out_pick_d;
      out_reld_q <= out_reld_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_vld_q;
  assign current_task_o = out_cur_q;
  assign picked_o       = out_pick_q;
  assign reloaded_o     = out_reld_q;

  `PTS_ASSERT_NOW(a_pick_xor_reload, clk_i, rst_ni, out_vld_q, !(out_pick_q && out_reld_q), "picked and reloaded both set")
  `PTS_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q != S_IDLE, "request accepted but sequencer stayed idle")
  `PTS_ASSERT_NOW(a_cur_in_range, clk_i, rst_ni, 1'b1, 7'(cur_q) < 7'(NUM_TASKS), "current task out of range")
  `PTS_ASSERT_NOW(a_no_same_entry, clk_i, rst_ni, mem_ctrl.rd_en && mem_ctrl.wr_en, rd_addr != wr_addr, "read and write hit the same entry")

endmodule

// File: tb/sv/priority_tick_scheduler_unit_tb.sv
module priority_tick_scheduler_unit_tb;
  import pts_pkg::*;

  localparam int NumTasks    = NumTasksDef;
  localparam int RandItems   = 1030;
  localparam int StuckLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 2 * NumTasks + 10;
  localparam int NumDirRows  = 25;

  typedef struct packed {
    logic [TaskIdxW-1:0] task_id;
    logic                picked;
    logic                reloaded;
  } sched_result_t;

  typedef struct packed {
    pts_cmd_e            cmd;
    logic [TaskIdxW-1:0] idx;
    logic [ValueW-1:0]   value;
    logic                typed;
    sched_result_t       result;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i;
  logic [TaskIdxW-1:0] task_index_i;
  logic [ValueW-1:0]   value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [TaskIdxW-1:0] current_task_o;
  logic                picked_o;
  logic                reloaded_o;

  // Shadow copy of the task table
  logic [ValueW-1:0]   budget_q [NumTasks];
  logic [ValueW-1:0]   prio_q [NumTasks];
  logic                blocked_q [NumTasks];
  logic [TaskIdxW-1:0] running_task;

  sched_result_t awaited_results [$];
  int            requests_sent;
  int            results_seen;
  int            picks_seen;
  int            reloads_seen;
  int            error_count;
  int            stuck_cycles;
  bit            gaps_on;
  bit            long_hold_req;

  // Directed requests: typed results only where they follow from reset or extremes
  stim_row_t dir_rows [NumDirRows] = '{
    '{CmdSched,    6'd0,                    8'h00, 1'b1, '{6'd0, 1'b0, 1'b1}},
    '{CmdTick,     6'd0,                    8'h00, 1'b1, '{6'd0, 1'b0, 1'b1}},
    '{CmdSetPrio,  6'd63,                   8'hFF, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{CmdSetBlock, TaskIdxW'(NumTasks),     8'h01, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{CmdSetPrio,  6'd0,                    8'hFF, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{CmdSetPrio,  TaskIdxW'(NumTasks - 1), 8'hFF, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{CmdSched,    6'd0,                    8'h00, 1'b1, '{6'd0, 1'b1, 1'b0}},
    '{CmdSetBlock, 6'd0,                    8'h01, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{CmdSetBlock, 6'd0,                    8'hFE, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{CmdSetBlock, 6'd0,                    8'hFF, 1'b1, '{6'd0, 1'b0, 1'b0}},
    '{CmdTick,     6'd0,                    8'hFF,
      1'b1, '{TaskIdxW'(NumTasks - 1), 1'b1, 1'b0}},
    '{CmdSetPrio,  6'd3,                    8'h01,
      1'b1, '{TaskIdxW'(NumTasks - 1), 1'b0, 1'b0}},
    '{CmdSetBlock, TaskIdxW'(NumTasks - 1), 8'h01,
      1'b1, '{TaskIdxW'(NumTasks - 1), 1'b0, 1'b0}},
    '{CmdSched,    6'd0,                    8'h00, 1'b1, '{6'd3, 1'b1, 1'b0}},
    '{CmdTick,     6'd0,                    8'h00, 1'b1, '{6'd3, 1'b0, 1'b1}},
    '{CmdTick,     6'd0,                    8'h00, 1'b1, '{6'd3, 1'b0, 1'b1}},
    '{CmdSetBlock, 6'd0,                    8'h00, 1'b1, '{6'd3, 1'b0, 1'b0}},
    '{CmdSetBlock, TaskIdxW'(NumTasks - 1), 8'h00, 1'b1, '{6'd3, 1'b0, 1'b0}},
    '{CmdSetPrio,  6'd5,                    8'h80, 1'b0, '0},
    '{CmdTick,     6'd0,                    8'hAA, 1'b0, '0},
    '{CmdSetPrio,  6'd2,                    8'h00, 1'b0, '0},
    '{CmdSched,    6'd0,                    8'h55, 1'b0, '0},
    '{CmdSetPrio,  6'd6,                    8'h55, 1'b0, '0},
    '{CmdTick,     6'd0,                    8'h00, 1'b0, '0},
    '{CmdSched,    6'd0,                    8'h00, 1'b0, '0}
  };

  priority_tick_scheduler_unit #(
    .NUM_TASKS(NumTasks)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .task_index_i   (task_index_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_task_o (current_task_o),
    .picked_o       (picked_o),
    .reloaded_o     (reloaded_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the shadow table by one request and return the schedule it yields
  function automatic sched_result_t apply_request(pts_cmd_e cmd, logic [TaskIdxW-1:0] idx,
                                                  logic [ValueW-1:0] value);
    sched_result_t     res;
    logic [ValueW-1:0] best;
    res  = '0;
    best = '0;
    case (cmd)
      CmdSetPrio: begin
        if (idx < NumTasks) begin
          prio_q[idx]   = value;
          budget_q[idx] = value;
        end
      end
      CmdSetBlock: begin
        if (idx < NumTasks) blocked_q[idx] = value[0];
      end
      default: begin
        // tick charges the running task even when it is blocked; never wrap
        if (cmd == CmdTick && running_task < NumTasks && budget_q[running_task] != '0) begin
          budget_q[running_task] = budget_q[running_task] - 1'b1;
        end
        for (int i = 0; i < NumTasks; i++) begin
          if (!blocked_q[i] && budget_q[i] > best) begin
            best         = budget_q[i];
            running_task = TaskIdxW'(i);
          end
        end
        if (best == '0) begin
          for (int i = 0; i < NumTasks; i++) budget_q[i] = prio_q[i];
          res.reloaded = 1'b1;
        end else begin
          res.picked = 1'b1;
        end
      end
    endcase
    res.task_id = running_task;
    return res;
  endfunction

  // Offer one request after a random gap, hold it until taken, then queue its result
  task automatic issue_request(input pts_cmd_e cmd, input logic [TaskIdxW-1:0] idx,
                               input logic [ValueW-1:0] value, input logic typed,
                               input sched_result_t typed_result);
    int            gap;
    sched_result_t predicted;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    task_index_i <= idx;
    value_i      <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_request(cmd, idx, value);
    awaited_results.push_back(typed ? typed_result : predicted);
    requests_sent++;
  endtask

  // Sender: reset, directed table, then random traffic
  initial begin : drive_requests
    pts_cmd_e            cmd;
    logic [TaskIdxW-1:0] idx;
    logic [ValueW-1:0]   value;
    int                  pick;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    cmd_i         <= '0;
    task_index_i  <= '0;
    value_i       <= '0;
    gaps_on       = 1'b1;
    long_hold_req = 1'b0;
    for (int i = 0; i < NumTasks; i++) begin
      budget_q[i]  = '0;
      prio_q[i]    = '0;
      blocked_q[i] = 1'b0;
    end
    running_task = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      issue_request(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].value,
                    dir_rows[r].typed, dir_rows[r].result);
    end

    for (int k = 0; k < RandItems; k++) begin
      // every third stretch of requests runs without gaps on either side
      gaps_on = ((k / 120) % 3) != 2;
      if (k == 400) long_hold_req = 1'b1;
      if (k == 700) begin
        in_valid_i <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd = CmdSetPrio;
      else if (pick < 40) cmd = CmdSetBlock;
      else if (pick < 60) cmd = CmdSched;
      else cmd = CmdTick;
      if ($urandom_range(0, 9) == 0) idx = TaskIdxW'($urandom_range(NumTasks, 63));
      else idx = TaskIdxW'($urandom_range(0, NumTasks - 1));
      value = ValueW'($urandom_range(0, 255));
      // small priorities let ticks drain budgets and force reloads
      if (cmd == CmdSetPrio && $urandom_range(0, 1) == 0) value = ValueW'($urandom_range(0, 4));
      if (cmd == CmdSetBlock) value[0] = ($urandom_range(0, 3) == 0);
      issue_request(cmd, idx, value, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d requests (%0d directed, %0d random); checked %0d results.",
             requests_sent, NumDirRows, RandItems, results_seen);
    $display("Results with a pick: %0d, with a reload: %0d.", picks_seen, reloads_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random stalls plus one long hold to back up the input
  initial begin : drive_result_stall
    int stall_len;
    out_stall_i <= 1'b1;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      stall_len = gaps_on ? $urandom_range(0, 8) : 0;
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each taken result with the oldest queued expectation
  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: current_task %0d picked %0d reloaded %0d",
               current_task_o, picked_o, reloaded_o);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        if (picked_o) picks_seen++;
        if (reloaded_o) reloads_seen++;
        if (current_task_o !== want.task_id) begin
          $error("current_task mismatch: expected %0d, got %0d", want.task_id, current_task_o);
          error_count++;
        end
        if (picked_o !== want.picked) begin
          $error("picked mismatch: expected %0d, got %0d", want.picked, picked_o);
          error_count++;
        end
        if (reloaded_o !== want.reloaded) begin
          $error("reloaded mismatch: expected %0d, got %0d", want.reloaded, reloaded_o);
          error_count++;
        end
      end
    end
  end

  // Count cycles with no traffic on either side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("Timeout: no request or result taken for %0d cycles.", StuckLimit);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
